### hw/rtl/ggam_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ggam_pkg
// Shared constants for the GB2312 glyph address mapper: code ranges, font ROM
// bases, read lengths, glyph kinds and column advances.
// ----------------------------------------------------------------------------
package ggam_pkg;

    typedef logic [1:0] glyph_kind_t;

    localparam glyph_kind_t KIND_HANZI  = 2'd0;
    localparam glyph_kind_t KIND_SYMBOL = 2'd1;
    localparam glyph_kind_t KIND_ASCII16 = 2'd2;
    localparam glyph_kind_t KIND_ASCII7 = 2'd3;

    localparam logic [5:0] LEN_16X16 = 6'd32;
    localparam logic [5:0] LEN_8X16  = 6'd16;
    localparam logic [5:0] LEN_5X7   = 6'd8;

    localparam logic [7:0] ADV_16X16 = 8'd16;
    localparam logic [7:0] ADV_8X16  = 8'd8;
    localparam logic [7:0] ADV_5X7   = 8'd6;

    localparam logic [7:0] HZ_LEAD_LO  = 8'hB0;
    localparam logic [7:0] HZ_LEAD_HI  = 8'hF7;
    localparam logic [7:0] SYM_LEAD_LO = 8'hA1;
    localparam logic [7:0] SYM_LEAD_HI = 8'hA3;
    localparam logic [7:0] TRAIL_LO    = 8'hA1;
    localparam logic [7:0] PRINT_LO    = 8'h20;
    localparam logic [7:0] PRINT_HI    = 8'h7E;

    localparam logic [12:0] ROW_CELLS  = 13'd94;
    localparam logic [12:0] HANZI_SKIP = 13'd846;

    localparam logic [23:0] ASCII16_BASE = 24'h03CF80;
    localparam logic [23:0] ASCII7_BASE  = 24'h03BFC0;

endpackage

### hw/rtl/gb2312_glyph_address_mapper.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gb2312_glyph_address_mapper
// Turns a text byte stream into font ROM glyph requests (address, length,
// kind, page, column) for GB2312 16x16, ASCII 8x16 and ASCII 5x7 glyphs.
// ----------------------------------------------------------------------------
// Path: each accepted byte passes the input register and then the result
// register; a held result with out_ready low stalls both.
// Throughput: one byte per cycle unless a held result stalls it; the decode
// and address math fit in the one stage between the input and result registers.
// Reset: rst_n clears the string state, the lead-byte state and both valid
// flags; no string is active after reset.
module gb2312_glyph_address_mapper
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  char_byte,
    input  logic        string_start,
    input  logic [2:0]  start_page,
    input  logic [7:0]  start_column,
    input  logic        small_font,

    output logic        out_valid,
    input  logic        out_ready,
    output logic [23:0] rom_address,
    output logic [5:0]  read_length,
    output logic [1:0]  glyph_kind,
    output logic [2:0]  glyph_page,
    output logic [7:0]  glyph_column
);

    // input register
    logic       s1_valid_reg;
    logic [7:0] s1_byte_reg;
    logic       s1_start_reg;
    logic [2:0] s1_page_reg;
    logic [7:0] s1_column_reg;
    logic       s1_small_reg;

    // string state
    logic [7:0] pending_lead_reg, pending_lead_next;
    logic       lead_waiting_reg, lead_waiting_next;
    logic [7:0] column_reg, column_next;
    logic [2:0] page_reg, page_next;
    logic       small_mode_reg, small_mode_next;
    logic       active_reg, active_next;

    // result register
    logic                  out_valid_reg;
    logic [23:0]           address_reg;
    logic [5:0]            length_reg;
    ggam_pkg::glyph_kind_t kind_reg;
    logic [2:0]            opage_reg;
    logic [7:0]            ocolumn_reg;

    logic                  s1_advance;
    logic                  emit;
    logic [23:0]           address_calc;
    logic [5:0]            length_calc;
    ggam_pkg::glyph_kind_t kind_calc;
    logic [7:0]            advance;
    logic [7:0]            column_eff;
    logic                  lead_eff;

    logic [6:0]  lead_hz_off;
    logic [1:0]  lead_sym_off;
    logic [6:0]  trail_off;
    logic [6:0]  ascii_off;
    logic [12:0] hz_cell;
    logic [12:0] sym_cell;
    logic        is_print;
    logic        is_lead_hz;
    logic        is_lead_sym;

    assign s1_advance = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready   = !s1_valid_reg || s1_advance;

    // address math on the input register
    assign lead_hz_off  = 7'(pending_lead_reg - ggam_pkg::HZ_LEAD_LO);
    assign lead_sym_off = 2'(pending_lead_reg - ggam_pkg::SYM_LEAD_LO);
    assign trail_off    = 7'(s1_byte_reg - ggam_pkg::TRAIL_LO);
    assign ascii_off    = 7'(s1_byte_reg - ggam_pkg::PRINT_LO);
    assign hz_cell      = 13'(lead_hz_off) * ggam_pkg::ROW_CELLS + 13'(trail_off)
                          + ggam_pkg::HANZI_SKIP;
    assign sym_cell     = 13'(lead_sym_off) * ggam_pkg::ROW_CELLS + 13'(trail_off);

    assign is_print    = (s1_byte_reg >= ggam_pkg::PRINT_LO)
                         && (s1_byte_reg <= ggam_pkg::PRINT_HI);
    assign is_lead_hz  = (s1_byte_reg >= ggam_pkg::HZ_LEAD_LO)
                         && (s1_byte_reg <= ggam_pkg::HZ_LEAD_HI);
    assign is_lead_sym = (s1_byte_reg >= ggam_pkg::SYM_LEAD_LO)
                         && (s1_byte_reg <= ggam_pkg::SYM_LEAD_HI);

    always_comb
    begin
        page_next         = s1_start_reg ? s1_page_reg : page_reg;
        column_eff        = s1_start_reg ? s1_column_reg : column_reg;
        small_mode_next   = s1_start_reg ? s1_small_reg : small_mode_reg;
        active_next       = s1_start_reg || active_reg;
        lead_eff          = !s1_start_reg && lead_waiting_reg;
        lead_waiting_next = lead_eff;
        pending_lead_next = s1_start_reg ? 8'd0 : pending_lead_reg;
        emit              = 1'b0;
        address_calc      = '0;
        length_calc       = ggam_pkg::LEN_16X16;
        kind_calc         = ggam_pkg::KIND_HANZI;
        advance           = 8'd0;

        if (active_next)
        begin
            if (lead_eff && (s1_byte_reg >= ggam_pkg::TRAIL_LO))
            begin
                lead_waiting_next = 1'b0;
                pending_lead_next = 8'd0;
                emit              = 1'b1;
                length_calc       = ggam_pkg::LEN_16X16;
                advance           = ggam_pkg::ADV_16X16;
                if (pending_lead_reg >= ggam_pkg::HZ_LEAD_LO)
                begin
                    kind_calc    = ggam_pkg::KIND_HANZI;
                    address_calc = {6'd0, hz_cell, 5'd0};
                end
                else
                begin
                    kind_calc    = ggam_pkg::KIND_SYMBOL;
                    address_calc = {6'd0, sym_cell, 5'd0};
                end
            end
            else
            begin
                // drop any waiting lead; handle the byte on its own
                lead_waiting_next = 1'b0;
                pending_lead_next = 8'd0;
                if (s1_byte_reg == 8'd0)
                begin
                    active_next = 1'b0;
                end
                else if (small_mode_next)
                begin
                    if (is_print)
                    begin
                        emit         = 1'b1;
                        kind_calc    = ggam_pkg::KIND_ASCII7;
                        length_calc  = ggam_pkg::LEN_5X7;
                        advance      = ggam_pkg::ADV_5X7;
                        address_calc = 24'({ascii_off, 3'd0}) + ggam_pkg::ASCII7_BASE;
                    end
                end
                else if (is_lead_hz || is_lead_sym)
                begin
                    lead_waiting_next = 1'b1;
                    pending_lead_next = s1_byte_reg;
                end
                else if (is_print)
                begin
                    emit         = 1'b1;
                    kind_calc    = ggam_pkg::KIND_ASCII16;
                    length_calc  = ggam_pkg::LEN_8X16;
                    advance      = ggam_pkg::ADV_8X16;
                    address_calc = 24'({ascii_off, 4'd0}) + ggam_pkg::ASCII16_BASE;
                end
            end
        end

        column_next = column_eff + advance;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            pending_lead_reg <= 8'd0;
            lead_waiting_reg <= 1'b0;
            column_reg       <= 8'd0;
            page_reg         <= 3'd0;
            small_mode_reg   <= 1'b0;
            active_reg       <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            if (s1_advance)
            begin
                out_valid_reg    <= emit;
                pending_lead_reg <= pending_lead_next;
                lead_waiting_reg <= lead_waiting_next;
                column_reg       <= column_next;
                page_reg         <= page_next;
                small_mode_reg   <= small_mode_next;
                active_reg       <= active_next;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            s1_byte_reg   <= char_byte;
            s1_start_reg  <= string_start;
            s1_page_reg   <= start_page;
            s1_column_reg <= start_column;
            s1_small_reg  <= small_font;
        end
        if (s1_advance && emit)
        begin
            address_reg <= address_calc;
            length_reg  <= length_calc;
            kind_reg    <= kind_calc;
            opage_reg   <= page_next;
            ocolumn_reg <= column_eff;
        end
    end

    assign out_valid    = out_valid_reg;
    assign rom_address  = address_reg;
    assign read_length  = length_reg;
    assign glyph_kind   = kind_reg;
    assign glyph_page   = opage_reg;
    assign glyph_column = ocolumn_reg;

    // a lead byte only waits in large mode inside a string, with a lead code no lower than the symbol range
    a_lead_large_only : assert property (@(posedge clk) disable iff (!rst_n)
        lead_waiting_reg |-> (!small_mode_reg && active_reg
                              && pending_lead_reg >= ggam_pkg::SYM_LEAD_LO))
        else $error("lead byte waiting in an invalid state");

    // a stalled result blocks the input stage from advancing
    a_hold_on_stall : assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && out_valid_reg && !out_ready) |=> s1_valid_reg)
        else $error("input stage lost a beat while the result stalled");

    // read length follows glyph kind
    a_len_kind : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |->
            ((kind_reg == ggam_pkg::KIND_ASCII7 && length_reg == ggam_pkg::LEN_5X7)
             || (kind_reg == ggam_pkg::KIND_ASCII16 && length_reg == ggam_pkg::LEN_8X16)
             || ((kind_reg == ggam_pkg::KIND_HANZI || kind_reg == ggam_pkg::KIND_SYMBOL)
                 && length_reg == ggam_pkg::LEN_16X16)))
        else $error("read length does not match glyph kind");

    // a beat that neither starts a string nor arrives in one produces no result
    a_idle_no_result : assert property (@(posedge clk) disable iff (!rst_n)
        (s1_advance && !s1_start_reg && !active_reg) |=> !out_valid_reg)
        else $error("result produced outside a string");

endmodule
